// ===== rtl/xpem_pkg.sv =====
// ----------------------------------------------------------------------------
// xpem_pkg
// Types, action codes and constants of the xoshiro256** generator with
// entropy mixing.
// ----------------------------------------------------------------------------
package xpem_pkg;

  typedef logic [63:0] word_t;
  typedef logic [1:0]  action_t;

  localparam action_t ACT_SEED    = 2'd0;
  localparam action_t ACT_ENTROPY = 2'd1;
  localparam action_t ACT_DRAW    = 2'd2;

  localparam word_t SM_GAMMA = 64'h9e3779b97f4a7c15;
  localparam word_t SM_MUL1  = 64'hbf58476d1ce4e5b9;
  localparam word_t SM_MUL2  = 64'h94d049bb133111eb;

  localparam int unsigned ROT_ENT_A = 19;
  localparam int unsigned ROT_ENT_B = 37;
  localparam int unsigned ROT_STATE = 45;
  localparam int unsigned ROT_OUT   = 7;
  localparam int unsigned SHL_T     = 17;

  function automatic word_t rotl(word_t v, int unsigned k);
    return (v << k) | (v >> (64 - k));
  endfunction

endpackage

// ===== rtl/xoshiro_prng_with_entropy_mix.sv =====
// ----------------------------------------------------------------------------
// xoshiro_prng_with_entropy_mix
// xoshiro256** generator with a one-time splitmix64 seeding sequence and
// entropy mixing. Seeding runs through one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
//
//   channel  handshake             payload
//   in       in_valid / in_stall   action, seed_value, entropy_word,
//                                  timestamp, tick_count
//   out      out_valid / out_stall random_value
//
// An entropy item, a repeated seed and the unused code complete on acceptance.
// A draw runs the state update on acceptance, then the output multiply.
// The first seed runs the accepting step, then four splitmix64 rounds, each
// one add step and two 64-bit multiplies on the 32x32 multiplier.
// Reset clears the state words and the seeded flag. A draw whose result
// finds the output register still stalled waits in ST_CALC.
module xoshiro_prng_with_entropy_mix (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  xpem_pkg::action_t      action,
  input  xpem_pkg::word_t        seed_value,
  input  xpem_pkg::word_t        entropy_word,
  input  xpem_pkg::word_t        timestamp,
  input  xpem_pkg::word_t        tick_count,
  output logic                   out_valid,
  input  logic                   out_stall,
  output xpem_pkg::word_t        random_value
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADD  = 3'd1;
  localparam logic [2:0] ST_MUL1 = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_CALC = 3'd4;

  logic [2:0]       state;
  logic [1:0]       cnt;
  logic [1:0]       idx;
  logic             seeded;
  xpem_pkg::word_t  gen_words [4];
  xpem_pkg::word_t  ctr;
  xpem_pkg::word_t  z;
  xpem_pkg::word_t  acc;
  xpem_pkg::word_t  prod;
  xpem_pkg::word_t  m5;

  logic             accept;
  xpem_pkg::word_t  ctr_next;
  xpem_pkg::word_t  mul_b;
  logic [31:0]      a_half;
  logic [31:0]      b_half;
  xpem_pkg::word_t  mul_sum;
  xpem_pkg::word_t  s1_x5;
  xpem_pkg::word_t  w0_n;
  xpem_pkg::word_t  w1_n;
  xpem_pkg::word_t  w2_n;
  xpem_pkg::word_t  w3_n;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  assign ctr_next = ctr + xpem_pkg::SM_GAMMA;
  assign mul_b    = (state == ST_MUL2) ? xpem_pkg::SM_MUL2 : xpem_pkg::SM_MUL1;
  assign a_half   = (cnt == 2'd2) ? z[63:32] : z[31:0];
  assign b_half   = (cnt == 2'd1) ? mul_b[63:32] : mul_b[31:0];
  assign mul_sum  = acc + {prod[31:0], 32'h0};

  assign s1_x5 = gen_words[1] + (gen_words[1] << 2);

  always_comb begin
    w2_n = gen_words[2] ^ gen_words[0];
    w3_n = gen_words[3] ^ gen_words[1];
    w1_n = gen_words[1] ^ w2_n;
    w0_n = gen_words[0] ^ w3_n;
    w2_n = w2_n ^ (gen_words[1] << xpem_pkg::SHL_T);
    w3_n = xpem_pkg::rotl(w3_n, xpem_pkg::ROT_STATE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= 2'd0;
      idx       <= 2'd0;
      seeded    <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        gen_words[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall && state != ST_CALC) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            priority if (action == xpem_pkg::ACT_SEED) begin
              if (!seeded) begin
                ctr   <= seed_value;
                idx   <= 2'd0;
                state <= ST_ADD;
              end
            end else if (action == xpem_pkg::ACT_ENTROPY) begin
              gen_words[0] <= gen_words[0] ^ entropy_word ^ timestamp;
              gen_words[1] <= gen_words[1] ^
                              xpem_pkg::rotl(entropy_word, xpem_pkg::ROT_ENT_A);
              gen_words[2] <= gen_words[2] ^ tick_count;
              gen_words[3] <= gen_words[3] ^
                              xpem_pkg::rotl(entropy_word, xpem_pkg::ROT_ENT_B);
            end else if (action == xpem_pkg::ACT_DRAW) begin
              m5           <= xpem_pkg::rotl(s1_x5, xpem_pkg::ROT_OUT);
              gen_words[0] <= w0_n ^ timestamp;
              gen_words[1] <= w1_n;
              gen_words[2] <= w2_n;
              gen_words[3] <= w3_n;
              state        <= ST_CALC;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_ADD: begin
          ctr   <= ctr_next;
          z     <= ctr_next ^ (ctr_next >> 30);
          cnt   <= 2'd0;
          state <= ST_MUL1;
        end
        ST_MUL1, ST_MUL2: begin
          prod <= a_half * b_half;
          cnt  <= cnt + 2'd1;
          if (cnt == 2'd1) begin
            acc <= prod;
          end else if (cnt == 2'd2) begin
            acc <= mul_sum;
          end
          if (cnt == 2'd3) begin
            if (state == ST_MUL1) begin
              z     <= mul_sum ^ (mul_sum >> 27);
              state <= ST_MUL2;
            end else begin
              gen_words[idx] <= mul_sum ^ (mul_sum >> 31);
              idx            <= idx + 2'd1;
              if (idx == 2'd3) begin
                seeded <= 1'b1;
                state  <= ST_IDLE;
              end else begin
                state <= ST_ADD;
              end
            end
          end
        end
        ST_CALC: begin
          if (!out_valid || !out_stall) begin
            random_value <= m5 + (m5 << 3);
            out_valid    <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall)
    else $error("input taken while busy");

  a_seeded_sticks: assert property (@(posedge clk) disable iff (rst)
    seeded |=> seeded)
    else $error("seeded flag cleared");

  a_seed_once: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD) |-> !seeded)
    else $error("seeding after seeded");

  a_calc_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC && !(out_valid && out_stall)) |=> out_valid)
    else $error("draw result lost");

endmodule

// ===== bench/xoshiro_prng_with_entropy_mix_test.sv =====
// ----------------------------------------------------------------------------
// xoshiro_prng_with_entropy_mix_test
// Self-checking bench for the xoshiro256** generator with entropy mixing.
// A driver feeds seed, entropy and draw items from a queue. A generator
// model of its own predicts every random word, and a monitor compares the
// drawn words in order. Both sides idle at random in several phases, and
// one long output hold-off backs the block up.
// ----------------------------------------------------------------------------
module xoshiro_prng_with_entropy_mix_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam xpem_pkg::action_t ACT_UNUSED  = 2'd3;
  localparam int                RAND_ITEMS  = 500;
  localparam int                HOLD_CYCLES = 300;
  localparam int                CYCLE_LIMIT = 400000;
  localparam int                DRAIN_WAIT  = 40;

  typedef struct packed {
    xpem_pkg::action_t act;
    xpem_pkg::word_t   seed;
    xpem_pkg::word_t   ent;
    xpem_pkg::word_t   ts;
    xpem_pkg::word_t   tick;
  } rng_req_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  xpem_pkg::action_t action = xpem_pkg::ACT_SEED;
  xpem_pkg::word_t   seed_value = '0;
  xpem_pkg::word_t   entropy_word = '0;
  xpem_pkg::word_t   timestamp = '0;
  xpem_pkg::word_t   tick_count = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  xpem_pkg::word_t   random_value;

  rng_req_t        pending_reqs[$];
  xpem_pkg::word_t expected_words[$];
  rng_req_t        cur_req;
  xpem_pkg::word_t gen_st[4];
  logic            gen_seeded;
  xpem_pkg::word_t exp_word;

  int total_reqs;
  int accepted_cnt = 0;
  int drawn_cnt = 0;
  int entropy_cnt = 0;
  int ignored_cnt = 0;
  int checked_cnt = 0;
  int error_cnt = 0;
  int hold_left = 0;
  int cycle_cnt = 0;
  logic hold_done = 1'b0;
  logic drv_load;

  xoshiro_prng_with_entropy_mix dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .seed_value   (seed_value),
    .entropy_word (entropy_word),
    .timestamp    (timestamp),
    .tick_count   (tick_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .random_value (random_value)
  );

  always #5 clk = ~clk;

  function automatic xpem_pkg::word_t rot64(xpem_pkg::word_t v, int unsigned k);
    logic [127:0] dbl;
    dbl = {v, v} << k;
    return dbl[127:64];
  endfunction

  function automatic xpem_pkg::word_t splitmix_step(inout xpem_pkg::word_t ctr);
    xpem_pkg::word_t z;
    ctr = ctr + xpem_pkg::SM_GAMMA;
    z = ctr;
    z = (z ^ (z >> 30)) * xpem_pkg::SM_MUL1;
    z = (z ^ (z >> 27)) * xpem_pkg::SM_MUL2;
    return z ^ (z >> 31);
  endfunction

  task automatic advance_generator(input rng_req_t r);
    xpem_pkg::word_t ctr;
    xpem_pkg::word_t t;
    xpem_pkg::word_t drawn;
    case (r.act)
      xpem_pkg::ACT_SEED: begin
        if (!gen_seeded) begin
          ctr = r.seed;
          for (int i = 0; i < 4; i++) gen_st[i] = splitmix_step(ctr);
          gen_seeded = 1'b1;
        end else begin
          ignored_cnt++;
        end
      end
      xpem_pkg::ACT_ENTROPY: begin
        gen_st[0] ^= r.ent ^ r.ts;
        gen_st[1] ^= rot64(r.ent, xpem_pkg::ROT_ENT_A);
        gen_st[2] ^= r.tick;
        gen_st[3] ^= rot64(r.ent, xpem_pkg::ROT_ENT_B);
        entropy_cnt++;
      end
      xpem_pkg::ACT_DRAW: begin
        drawn = rot64(gen_st[1] * 64'd5, xpem_pkg::ROT_OUT) * 64'd9;
        t = gen_st[1] << xpem_pkg::SHL_T;
        gen_st[2] ^= gen_st[0];
        gen_st[3] ^= gen_st[1];
        gen_st[1] ^= gen_st[2];
        gen_st[0] ^= gen_st[3];
        gen_st[2] ^= t;
        gen_st[3] = rot64(gen_st[3], xpem_pkg::ROT_STATE);
        gen_st[0] ^= r.ts;
        expected_words.push_back(drawn);
        drawn_cnt++;
      end
      default: ignored_cnt++;
    endcase
  endtask

  task automatic report_mismatch(input string what, input xpem_pkg::word_t got,
                                 input xpem_pkg::word_t want);
    $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
    error_cnt++;
  endtask

  function automatic int phase_now();
    if (accepted_cnt * 3 < total_reqs) return 0;
    if (accepted_cnt * 3 < total_reqs * 2) return 1;
    return 2;
  endfunction

  function automatic int send_idle_pct();
    case (phase_now())
      0: return 38;
      1: return 54;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct();
    case (phase_now())
      0: return 54;
      1: return 38;
      default: return 0;
    endcase
  endfunction

  function automatic xpem_pkg::word_t rand_word();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic rng_req_t mk_req(xpem_pkg::action_t a, xpem_pkg::word_t s,
                                      xpem_pkg::word_t e, xpem_pkg::word_t ts,
                                      xpem_pkg::word_t tk);
    rng_req_t r;
    r.act = a;
    r.seed = s;
    r.ent = e;
    r.ts = ts;
    r.tick = tk;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      drv_load = !in_valid || !in_stall;
      if (in_valid && !in_stall) begin
        advance_generator(cur_req);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (drv_load) begin
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          cur_req = pending_reqs.pop_front();
          in_valid     <= 1'b1;
          action       <= cur_req.act;
          seed_value   <= cur_req.seed;
          entropy_word <= cur_req.ent;
          timestamp    <= cur_req.ts;
          tick_count   <= cur_req.tick;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected random_value", random_value, '0);
        end else begin
          exp_word = expected_words.pop_front();
          if (random_value !== exp_word) report_mismatch("random_value", random_value, exp_word);
          checked_cnt++;
        end
      end
      out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < recv_idle_pct());
    end
  end

  // Long output hold-off during the phase without idling, so the block backs up.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && accepted_cnt * 6 >= total_reqs * 5) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int n_counted;
    int pick;
    xpem_pkg::action_t a;
    for (int i = 0; i < 4; i++) gen_st[i] = '0;
    gen_seeded = 1'b0;

    // Draws and entropy before seeding, the unused code, one real seed at the
    // top of the seed range, a repeated seed, and extreme field values.
    pending_reqs.push_back(mk_req(xpem_pkg::ACT_DRAW, '1, '1, '0, '1));
    pending_reqs.push_back(mk_req(xpem_pkg::ACT_DRAW, '0, '0, '1, '0));
    pending_reqs.push_back(mk_req(xpem_pkg::ACT_ENTROPY, '1, '1, '0, '1));
    pending_reqs.push_back(mk_req(xpem_pkg::ACT_DRAW, rand_word(), rand_word(), '0,
                                  rand_word()));
    pending_reqs.push_back(mk_req(ACT_UNUSED, '1, '1, '1, '1));
    pending_reqs.push_back(mk_req(xpem_pkg::ACT_DRAW, '0, '0, 64'h1, '0));
    pending_reqs.push_back(mk_req(xpem_pkg::ACT_SEED, '1, rand_word(), rand_word(),
                                  rand_word()));
    pending_reqs.push_back(mk_req(xpem_pkg::ACT_DRAW, '0, '0, '0, '0));
    pending_reqs.push_back(mk_req(xpem_pkg::ACT_SEED, '0, '0, '0, '0));
    pending_reqs.push_back(mk_req(xpem_pkg::ACT_DRAW, '1, '1, '1, '1));
    pending_reqs.push_back(mk_req(xpem_pkg::ACT_ENTROPY, '0, '0, '0, '0));
    pending_reqs.push_back(mk_req(xpem_pkg::ACT_DRAW, '0, '0, '0, '0));
    pending_reqs.push_back(mk_req(xpem_pkg::ACT_ENTROPY, '0, 64'hAAAA_AAAA_AAAA_AAAA,
                                  64'h5555_5555_5555_5555, 64'h8000_0000_0000_0001));
    pending_reqs.push_back(mk_req(xpem_pkg::ACT_DRAW, '0, '0, 64'h8000_0000_0000_0000,
                                  '0));
    pending_reqs.push_back(mk_req(xpem_pkg::ACT_ENTROPY, '1, '1, '1, '1));
    pending_reqs.push_back(mk_req(xpem_pkg::ACT_DRAW, '1, '1, '1, '1));
    pending_reqs.push_back(mk_req(ACT_UNUSED, '0, '0, '0, '0));
    pending_reqs.push_back(mk_req(xpem_pkg::ACT_DRAW, rand_word(), rand_word(),
                                  rand_word(), rand_word()));

    n_counted = 0;
    while (n_counted < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        a = xpem_pkg::ACT_DRAW;
      end else if (pick < 85) begin
        a = xpem_pkg::ACT_ENTROPY;
      end else if (pick < 93) begin
        a = xpem_pkg::ACT_SEED;
      end else begin
        a = ACT_UNUSED;
      end
      pending_reqs.push_back(mk_req(a, rand_word(), rand_word(), rand_word(), rand_word()));
      n_counted++;
    end
    total_reqs = pending_reqs.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() > 0 || in_valid || expected_words.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_words.size() > 0)
      report_mismatch("random_value still outstanding", '0, expected_words[0]);

    $display("Covered %0d items: %0d draws, %0d entropy mixes, %0d ignored items.",
             accepted_cnt, drawn_cnt, entropy_cnt, ignored_cnt);
    $display("Checked %0d random words, with a seed at the top of its range.", checked_cnt);
    if (error_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/xpem_pkg.sv
rtl/xoshiro_prng_with_entropy_mix.sv
bench/xoshiro_prng_with_entropy_mix_test.sv
